### src/irc_pkg.sv
// ----------------------------------------------------------------------------
// irc_pkg
// Shared types, codes and helpers of the ICMP receive classifier.
// ----------------------------------------------------------------------------
package irc_pkg;

	typedef enum logic [1:0] {
		ACT_REPLY    = 2'd0,
		ACT_CONSUMED = 2'd1,
		ACT_ERROR    = 2'd2,
		ACT_DROP     = 2'd3
	} action_t;

	localparam logic [7:0] TYPE_ECHO_REPLY    = 8'd0;
	localparam logic [7:0] TYPE_DEST_UNREACH  = 8'd3;
	localparam logic [7:0] TYPE_ECHO_REQUEST  = 8'd8;
	localparam logic [7:0] TYPE_TIME_EXCEEDED = 8'd11;
	localparam logic [7:0] CODE_ZERO          = 8'd0;
	localparam logic [7:0] UNREACH_CODE_MAX   = 8'd4;

	localparam logic [15:0] SUM_ONES = 16'hFFFF;
	localparam int LENGTH_W = 12;
	localparam int HEADER_BYTES = 8;
	localparam int QUEUE_DEPTH = 4;

	typedef struct packed {
		logic                bad;
		logic [15:0]         check_sum;
		logic [15:0]         reply_sum;
		logic [7:0]          msg_type;
		logic [7:0]          msg_code;
		logic [31:0]         src;
		logic [31:0]         dst;
		logic [LENGTH_W-1:0] length;
	} verdict_rec_t;

	function automatic logic [15:0] fold_add(input logic [15:0] a, input logic [15:0] b);
		logic [16:0] s;
		s = {1'b0, a} + {1'b0, b};
		return s[15:0] + {15'd0, s[16]};
	endfunction

endpackage

### src/irc_front.sv
// ----------------------------------------------------------------------------
// irc_front
// Accepts message bytes, keeps the running sums and the header fields, and
// hands a finished record to the queue on the last byte of each message.
// ----------------------------------------------------------------------------
module irc_front import irc_pkg::*; #(
	parameter int MAX_LENGTH = 2048
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         take,
	input  logic [7:0]   data_byte,
	input  logic         last_byte,
	input  logic [31:0]  source_address,
	input  logic [31:0]  destination_address,
	output logic         push,
	output verdict_rec_t push_rec
);

	localparam int CW = $clog2(MAX_LENGTH + 1);
	localparam logic [CW-1:0] MAX_COUNT = CW'(MAX_LENGTH);
	localparam logic [CW-1:0] HEADER_COUNT = CW'(HEADER_BYTES);

	logic [CW-1:0] count_q;
	logic          too_long_q;
	logic [15:0]   check_q;
	logic [15:0]   reply_q;
	logic [7:0]    pend_q;
	logic [7:0]    type_q;
	logic [7:0]    code_q;
	logic [31:0]   src_q;
	logic [31:0]   dst_q;

	logic          over;
	logic          is0, is1, is2, is3;
	logic [CW-1:0] count_nx;
	logic          too_long_nx;
	logic          add_en;
	logic [15:0]   word;
	logic [15:0]   rword;
	logic [15:0]   check_nx;
	logic [15:0]   reply_nx;
	logic [7:0]    pend_nx;
	logic [7:0]    type_nx;
	logic [7:0]    code_nx;
	logic [31:0]   src_nx;
	logic [31:0]   dst_nx;

	always_comb begin
		over = count_q >= MAX_COUNT;
		is0 = count_q == CW'(0);
		is1 = count_q == CW'(1);
		is2 = count_q == CW'(2);
		is3 = count_q == CW'(3);
		count_nx = over ? count_q : count_q + CW'(1);
		too_long_nx = too_long_q | over;
		src_nx = is0 ? source_address : src_q;
		dst_nx = is0 ? destination_address : dst_q;
		type_nx = (!over && is0) ? data_byte : type_q;
		code_nx = (!over && is1) ? data_byte : code_q;
		pend_nx = (!over && !count_q[0]) ? data_byte : pend_q;
		if (over) begin
			add_en = last_byte & MAX_COUNT[0];
			word = {pend_q, 8'd0};
			rword = {pend_q, 8'd0};
		end else if (count_q[0]) begin
			add_en = 1'b1;
			word = {pend_q, data_byte};
			rword = {(is1 || is3) ? 8'd0 : pend_q, is3 ? 8'd0 : data_byte};
		end else begin
			add_en = last_byte;
			word = {data_byte, 8'd0};
			rword = {(is0 || is2) ? 8'd0 : data_byte, 8'd0};
		end
		check_nx = add_en ? fold_add(check_q, word) : check_q;
		reply_nx = add_en ? fold_add(reply_q, rword) : reply_q;
	end

	assign push = take & last_byte;

	always_comb begin
		push_rec.bad = too_long_nx | (count_nx < HEADER_COUNT);
		push_rec.check_sum = check_nx;
		push_rec.reply_sum = reply_nx;
		push_rec.msg_type = type_nx;
		push_rec.msg_code = code_nx;
		push_rec.src = src_nx;
		push_rec.dst = dst_nx;
		push_rec.length = LENGTH_W'(count_nx);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			too_long_q <= 1'b0;
			check_q <= '0;
			reply_q <= '0;
			pend_q <= '0;
			type_q <= '0;
			code_q <= '0;
			src_q <= '0;
			dst_q <= '0;
		end else if (take) begin
			src_q <= src_nx;
			dst_q <= dst_nx;
			if (last_byte) begin
				count_q <= '0;
				too_long_q <= 1'b0;
				check_q <= '0;
				reply_q <= '0;
				pend_q <= '0;
				type_q <= '0;
				code_q <= '0;
			end else begin
				count_q <= count_nx;
				too_long_q <= too_long_nx;
				check_q <= check_nx;
				reply_q <= reply_nx;
				pend_q <= pend_nx;
				type_q <= type_nx;
				code_q <= code_nx;
			end
		end
	end

endmodule

### src/irc_queue.sv
// ----------------------------------------------------------------------------
// irc_queue
// Short first-in first-out queue of message records between the byte front
// end and the verdict back end.
// ----------------------------------------------------------------------------
module irc_queue import irc_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         push,
	input  verdict_rec_t push_rec,
	output logic         full,
	input  logic         pop,
	output logic         rd_valid,
	output verdict_rec_t rd_rec
);

	localparam int AW = $clog2(QUEUE_DEPTH);
	localparam logic [AW:0] DEPTH_COUNT = (AW + 1)'(QUEUE_DEPTH);

	verdict_rec_t  entries_q [QUEUE_DEPTH];
	logic [AW-1:0] wr_ptr_q;
	logic [AW-1:0] rd_ptr_q;
	logic [AW:0]   fill_q;

	assign full = fill_q == DEPTH_COUNT;
	assign rd_valid = fill_q != '0;
	assign rd_rec = entries_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			entries_q[wr_ptr_q] <= push_rec;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fill_q <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == AW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + AW'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == AW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + AW'(1);
			end
			if (push && !pop) begin
				fill_q <= fill_q + (AW + 1)'(1);
			end else if (pop && !push) begin
				fill_q <= fill_q - (AW + 1)'(1);
			end
		end
	end

endmodule

### src/irc_back.sv
// ----------------------------------------------------------------------------
// irc_back
// Takes message records from the queue, decides the verdict, keeps the error
// and drop counters, and holds the result word in the output register.
// ----------------------------------------------------------------------------
module irc_back import irc_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                rd_valid,
	input  verdict_rec_t        rd_rec,
	output logic                pop,
	output logic                result_valid,
	input  logic                result_stall,
	output logic [1:0]          action,
	output logic [15:0]         reply_checksum,
	output logic [31:0]         reply_source,
	output logic [31:0]         reply_destination,
	output logic [LENGTH_W-1:0] message_length,
	output logic [31:0]         error_total,
	output logic [31:0]         drop_total
);

	logic                valid_q;
	logic [31:0]         err_q;
	logic [31:0]         drop_q;
	action_t             action_q;
	logic [15:0]         chk_q;
	logic [31:0]         rsrc_q;
	logic [31:0]         rdst_q;
	logic [LENGTH_W-1:0] len_q;

	logic    load;
	logic    consumed;
	action_t verdict;

	always_comb begin
		case (rd_rec.msg_type)
			TYPE_ECHO_REPLY:    consumed = rd_rec.msg_code == CODE_ZERO;
			TYPE_DEST_UNREACH:  consumed = rd_rec.msg_code <= UNREACH_CODE_MAX;
			TYPE_TIME_EXCEEDED: consumed = rd_rec.msg_code == CODE_ZERO;
			default:            consumed = 1'b0;
		endcase
		if (rd_rec.bad || rd_rec.check_sum != SUM_ONES) begin
			verdict = ACT_ERROR;
		end else if (rd_rec.msg_type == TYPE_ECHO_REQUEST && rd_rec.msg_code == CODE_ZERO) begin
			verdict = ACT_REPLY;
		end else if (consumed) begin
			verdict = ACT_CONSUMED;
		end else begin
			verdict = ACT_DROP;
		end
	end

	assign load = !valid_q || !result_stall;
	assign pop = rd_valid && load;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			err_q <= '0;
			drop_q <= '0;
		end else begin
			if (load) begin
				valid_q <= rd_valid;
			end
			if (pop && verdict == ACT_ERROR) begin
				err_q <= err_q + 32'd1;
			end
			if (pop && verdict == ACT_DROP) begin
				drop_q <= drop_q + 32'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			action_q <= verdict;
			len_q <= rd_rec.length;
			if (verdict == ACT_REPLY) begin
				chk_q <= ~rd_rec.reply_sum;
				rsrc_q <= rd_rec.dst;
				rdst_q <= rd_rec.src;
			end else begin
				chk_q <= '0;
				rsrc_q <= '0;
				rdst_q <= '0;
			end
		end
	end

	assign result_valid = valid_q;
	assign action = action_q;
	assign reply_checksum = chk_q;
	assign reply_source = rsrc_q;
	assign reply_destination = rdst_q;
	assign message_length = len_q;
	assign error_total = err_q;
	assign drop_total = drop_q;

endmodule

### src/icmp_receive_classifier.sv
// ----------------------------------------------------------------------------
// icmp_receive_classifier
// Takes one byte per cycle while the queue has room; the running
// one's-complement add sets that rate. Each verdict reaches the result port
// via the queue and the output register, up to four queued behind a stall.
// Reset clears the message state, the counters and the queue at once.
// ----------------------------------------------------------------------------
module icmp_receive_classifier import irc_pkg::*; #(
	parameter int MAX_LENGTH = 2048
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                item_valid,
	output logic                item_stall,
	input  logic [7:0]          data_byte,
	input  logic                last_byte,
	input  logic [31:0]         source_address,
	input  logic [31:0]         destination_address,
	output logic                result_valid,
	input  logic                result_stall,
	output logic [1:0]          action,
	output logic [15:0]         reply_checksum,
	output logic [31:0]         reply_source,
	output logic [31:0]         reply_destination,
	output logic [LENGTH_W-1:0] message_length,
	output logic [31:0]         error_total,
	output logic [31:0]         drop_total
);

	logic         take;
	logic         push;
	logic         full;
	logic         pop;
	logic         rd_valid;
	verdict_rec_t push_rec;
	verdict_rec_t rd_rec;

	assign item_stall = full;
	assign take = item_valid && !full;

	irc_front #(
		.MAX_LENGTH(MAX_LENGTH)
	) u_front (
		.clk                (clk),
		.arst_n             (arst_n),
		.take               (take),
		.data_byte          (data_byte),
		.last_byte          (last_byte),
		.source_address     (source_address),
		.destination_address(destination_address),
		.push               (push),
		.push_rec           (push_rec)
	);

	irc_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.push_rec(push_rec),
		.full    (full),
		.pop     (pop),
		.rd_valid(rd_valid),
		.rd_rec  (rd_rec)
	);

	irc_back u_back (
		.clk              (clk),
		.arst_n           (arst_n),
		.rd_valid         (rd_valid),
		.rd_rec           (rd_rec),
		.pop              (pop),
		.result_valid     (result_valid),
		.result_stall     (result_stall),
		.action           (action),
		.reply_checksum   (reply_checksum),
		.reply_source     (reply_source),
		.reply_destination(reply_destination),
		.message_length   (message_length),
		.error_total      (error_total),
		.drop_total       (drop_total)
	);

endmodule

### src/irc_checker.sv
// ----------------------------------------------------------------------------
// irc_checker
// Port-level checks of the ICMP receive classifier, bound to the top level.
// ----------------------------------------------------------------------------
module irc_checker import irc_pkg::*; (
	input logic        clk,
	input logic        arst_n,
	input logic        result_valid,
	input logic        result_stall,
	input logic [1:0]  action,
	input logic [15:0] reply_checksum,
	input logic [31:0] reply_source,
	input logic [31:0] reply_destination,
	input logic [31:0] error_total,
	input logic [31:0] drop_total
);

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_stall |=> result_valid && $stable(action))
		else $error("stalled result word was dropped or changed");

	a_reply_fields: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && action != ACT_REPLY |->
			reply_checksum == 16'd0 && reply_source == 32'd0 && reply_destination == 32'd0)
		else $error("reply fields set on a word that is not an echo reply");

	a_error_step: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && $past(result_valid && !result_stall) |->
			error_total == $past(error_total) + {31'd0, action == ACT_ERROR})
		else $error("error total does not follow the verdicts");

	a_drop_step: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && $past(result_valid && !result_stall) |->
			drop_total == $past(drop_total) + {31'd0, action == ACT_DROP})
		else $error("drop total does not follow the verdicts");

endmodule

bind icmp_receive_classifier irc_checker u_irc_checker (.*);

### tb/sv/icmp_receive_classifier_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// icmp_receive_classifier_tb
// Self-checking bench for the ICMP receive classifier. Whole messages are
// built with correct or damaged checksums and fed in one byte per word. A
// model in the bench tracks the running sums, the header bytes and the
// counters, and it checks every verdict field by field. Both ports idle and
// stall at random, each alone in some phases and both together in one.
// ----------------------------------------------------------------------------
module icmp_receive_classifier_tb;
	import irc_pkg::*;

	localparam int MAX_LEN = 2048;
	localparam int PHASE_BYTES = 320;
	localparam int DRAIN_CYCLES = 20;
	localparam int WATCHDOG_LIMIT = 5000;

	typedef enum int {FILL_RANDOM, FILL_ZERO, FILL_ONES} fill_t;

	typedef struct packed {
		logic [7:0]  data;
		logic        last;
		logic [31:0] src;
		logic [31:0] dst;
	} wire_byte_t;

	typedef struct packed {
		action_t             act;
		logic [15:0]         chk;
		logic [31:0]         rsrc;
		logic [31:0]         rdst;
		logic [LENGTH_W-1:0] len;
		logic [31:0]         errs;
		logic [31:0]         drops;
	} verdict_t;

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                item_valid = 1'b0;
	logic                item_stall;
	logic [7:0]          data_byte = 8'h00;
	logic                last_byte = 1'b0;
	logic [31:0]         source_address = 32'h0;
	logic [31:0]         destination_address = 32'h0;
	logic                result_valid;
	logic                result_stall = 1'b0;
	logic [1:0]          action;
	logic [15:0]         reply_checksum;
	logic [31:0]         reply_source;
	logic [31:0]         reply_destination;
	logic [LENGTH_W-1:0] message_length;
	logic [31:0]         error_total;
	logic [31:0]         drop_total;

	wire_byte_t wire_bytes[$];
	verdict_t   verdicts_due[$];
	wire_byte_t next_byte;
	verdict_t   new_verdict;
	verdict_t   want;

	int sender_idle_pct = 0;
	int receiver_stall_pct = 0;
	int bytes_queued = 0;
	int bytes_taken = 0;
	int messages_queued = 0;
	int results_checked = 0;
	int mismatches = 0;
	int quiet_cycles = 0;
	int action_seen[4] = '{0, 0, 0, 0};

	// Running state of the message being received.
	logic [LENGTH_W-1:0] msg_count = '0;
	logic                over_long = 1'b0;
	logic [15:0]         rx_sum = '0;
	logic [15:0]         tx_sum = '0;
	logic [7:0]          high_byte = '0;
	logic [7:0]          msg_type = '0;
	logic [7:0]          msg_code = '0;
	logic [31:0]         held_src = '0;
	logic [31:0]         held_dst = '0;
	logic [31:0]         bad_msg_count = '0;
	logic [31:0]         rx_drops = '0;

	icmp_receive_classifier #(.MAX_LENGTH(MAX_LEN)) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.item_valid(item_valid),
		.item_stall(item_stall),
		.data_byte(data_byte),
		.last_byte(last_byte),
		.source_address(source_address),
		.destination_address(destination_address),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.action(action),
		.reply_checksum(reply_checksum),
		.reply_source(reply_source),
		.reply_destination(reply_destination),
		.message_length(message_length),
		.error_total(error_total),
		.drop_total(drop_total)
	);

	always #1 clk = ~clk;

	function automatic logic [15:0] ones_add(input logic [15:0] a, input logic [15:0] b);
		int unsigned s;
		s = a + b;
		s = (s & 32'hFFFF) + (s >> 16);
		return s[15:0];
	endfunction

	function automatic bit take_icmp_byte(input wire_byte_t w, output verdict_t v);
		logic [LENGTH_W-1:0] idx;
		logic [7:0]          hi;
		logic                ok;
		idx = msg_count;
		v = '0;
		if (idx == 0) begin
			held_src = w.src;
			held_dst = w.dst;
		end
		if (idx >= MAX_LEN) begin
			over_long = 1'b1;
		end else begin
			if (idx == 0)
				msg_type = w.data;
			else if (idx == 1)
				msg_code = w.data;
			if (!idx[0]) begin
				high_byte = w.data;
			end else begin
				rx_sum = ones_add(rx_sum, {high_byte, w.data});
				hi = (idx == 1 || idx == 3) ? 8'h00 : high_byte;
				tx_sum = ones_add(tx_sum, {hi, (idx == 3) ? 8'h00 : w.data});
			end
			msg_count = idx + 1'b1;
		end
		if (!w.last)
			return 1'b0;
		if (msg_count[0]) begin
			rx_sum = ones_add(rx_sum, {high_byte, 8'h00});
			hi = (msg_count == 1 || msg_count == 3) ? 8'h00 : high_byte;
			tx_sum = ones_add(tx_sum, {hi, 8'h00});
		end
		ok = !over_long && msg_count >= HEADER_BYTES && rx_sum == SUM_ONES;
		v.len = msg_count;
		if (!ok) begin
			bad_msg_count = bad_msg_count + 1;
			v.act = ACT_ERROR;
		end else if (msg_type == TYPE_ECHO_REQUEST && msg_code == CODE_ZERO) begin
			v.act = ACT_REPLY;
			v.chk = ~tx_sum;
			v.rsrc = held_dst;
			v.rdst = held_src;
		end else if ((msg_type == TYPE_ECHO_REPLY && msg_code == CODE_ZERO) ||
				(msg_type == TYPE_DEST_UNREACH && msg_code <= UNREACH_CODE_MAX) ||
				(msg_type == TYPE_TIME_EXCEEDED && msg_code == CODE_ZERO)) begin
			v.act = ACT_CONSUMED;
		end else begin
			rx_drops = rx_drops + 1;
			v.act = ACT_DROP;
		end
		v.errs = bad_msg_count;
		v.drops = rx_drops;
		msg_count = '0;
		over_long = 1'b0;
		rx_sum = '0;
		tx_sum = '0;
		high_byte = '0;
		msg_type = '0;
		msg_code = '0;
		return 1'b1;
	endfunction

	task automatic check_field(input string name, input logic [31:0] exp_val,
			input logic [31:0] got_val);
		if (exp_val !== got_val) begin
			$display("%0t: %s expected %0h, got %0h", $time, name, exp_val, got_val);
			mismatches++;
		end
	endtask

	task automatic queue_message(input logic [7:0] typ, input logic [7:0] code, input int len,
			input bit corrupt, input fill_t fill);
		logic [7:0]  body[$];
		logic [15:0] sum;
		wire_byte_t  w;
		int          k;
		body = {};
		for (k = 0; k < len; k++) begin
			case (fill)
				FILL_ZERO: body.push_back(8'h00);
				FILL_ONES: body.push_back(8'hFF);
				default: body.push_back(8'($urandom_range(0, 255)));
			endcase
		end
		if (len > 0)
			body[0] = typ;
		if (len > 1)
			body[1] = code;
		if (len > 3) begin
			body[2] = 8'h00;
			body[3] = 8'h00;
			sum = '0;
			for (k = 0; k < len; k += 2)
				sum = ones_add(sum, {body[k], (k + 1 < len) ? body[k + 1] : 8'h00});
			sum = ~sum;
			body[2] = sum[15:8];
			body[3] = sum[7:0];
		end
		if (corrupt) begin
			k = $urandom_range(0, len - 1);
			body[k] = body[k] ^ (8'h01 << $urandom_range(0, 7));
		end
		for (k = 0; k < len; k++) begin
			w.data = body[k];
			w.last = (k == len - 1);
			case (fill)
				FILL_ZERO: begin
					w.src = 32'h0;
					w.dst = 32'h0;
				end
				FILL_ONES: begin
					w.src = 32'hFFFF_FFFF;
					w.dst = 32'hFFFF_FFFF;
				end
				default: begin
					w.src = $urandom;
					w.dst = $urandom;
				end
			endcase
			wire_bytes.push_back(w);
		end
		bytes_queued += len;
		messages_queued++;
	endtask

	task automatic queue_random_message();
		int         pick;
		int         len;
		logic [7:0] typ;
		logic [7:0] code;
		pick = $urandom_range(0, 99);
		code = CODE_ZERO;
		if (pick < 35) begin
			typ = TYPE_ECHO_REQUEST;
		end else if (pick < 40) begin
			typ = TYPE_ECHO_REQUEST;
			code = 8'($urandom_range(1, 255));
		end else if (pick < 50) begin
			typ = TYPE_ECHO_REPLY;
			if ($urandom_range(0, 2) == 0)
				code = 8'($urandom_range(1, 255));
		end else if (pick < 62) begin
			typ = TYPE_DEST_UNREACH;
			code = 8'($urandom_range(0, 7));
		end else if (pick < 70) begin
			typ = TYPE_TIME_EXCEEDED;
			code = 8'($urandom_range(0, 2));
		end else begin
			typ = 8'($urandom_range(0, 255));
			code = 8'($urandom_range(0, 255));
		end
		pick = $urandom_range(0, 99);
		if (pick < 85)
			len = $urandom_range(8, 40);
		else if (pick < 95)
			len = $urandom_range(1, 7);
		else
			len = $urandom_range(41, 120);
		queue_message(typ, code, len, $urandom_range(0, 99) < 15, FILL_RANDOM);
	endtask

	task automatic drain();
		while (results_checked < messages_queued)
			@(negedge clk);
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			item_valid <= 1'b0;
		end else begin
			if (item_valid && !item_stall) begin
				if (take_icmp_byte({data_byte, last_byte, source_address, destination_address},
						new_verdict))
					verdicts_due.push_back(new_verdict);
				bytes_taken++;
			end
			if (!item_valid || !item_stall) begin
				if (wire_bytes.size() != 0 && $urandom_range(0, 99) >= sender_idle_pct) begin
					next_byte = wire_bytes.pop_front();
					item_valid <= 1'b1;
					data_byte <= next_byte.data;
					last_byte <= next_byte.last;
					source_address <= next_byte.src;
					destination_address <= next_byte.dst;
				end else begin
					item_valid <= 1'b0;
				end
			end
		end
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_stall <= 1'b0;
		end else begin
			if (result_valid && !result_stall) begin
				results_checked++;
				if (verdicts_due.size() == 0) begin
					$display("%0t: verdict with none expected, action %0d", $time, action);
					mismatches++;
				end else begin
					want = verdicts_due.pop_front();
					check_field("action", want.act, action);
					check_field("reply_checksum", want.chk, reply_checksum);
					check_field("reply_source", want.rsrc, reply_source);
					check_field("reply_destination", want.rdst, reply_destination);
					check_field("message_length", want.len, message_length);
					check_field("error_total", want.errs, error_total);
					check_field("drop_total", want.drops, drop_total);
					action_seen[want.act]++;
				end
			end
			result_stall <= ($urandom_range(0, 99) < receiver_stall_pct);
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (item_valid && !item_stall) || (result_valid && !result_stall)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("%0t: no handshake for %0d cycles", $time, quiet_cycles);
			$display("Mismatches found");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	initial begin
		int idle_plan[5];
		int stall_plan[5];
		int ph;
		int start_bytes;
		idle_plan = '{0, 87, 0, 33, 0};
		stall_plan = '{0, 0, 87, 33, 0};
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		queue_message(8'hFF, 8'hFF, 1, 1'b0, FILL_ONES);
		queue_message(TYPE_ECHO_REQUEST, CODE_ZERO, 4, 1'b0, FILL_ZERO);
		queue_message(TYPE_ECHO_REQUEST, CODE_ZERO, 8, 1'b0, FILL_ONES);
		queue_message(TYPE_DEST_UNREACH, UNREACH_CODE_MAX, 8, 1'b0, FILL_ZERO);
		queue_message(TYPE_TIME_EXCEEDED, 8'd1, 9, 1'b0, FILL_RANDOM);
		drain();

		for (ph = 0; ph < 5; ph++) begin
			sender_idle_pct = idle_plan[ph];
			receiver_stall_pct = stall_plan[ph];
			start_bytes = bytes_queued;
			while (bytes_queued - start_bytes < PHASE_BYTES)
				queue_random_message();
			drain();
		end

		sender_idle_pct = 0;
		receiver_stall_pct = 0;
		queue_message(TYPE_ECHO_REQUEST, CODE_ZERO, 8, 1'b0, FILL_RANDOM);
		drain();
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Covered %0d bytes in %0d messages across five idle and stall phases.",
			bytes_taken, messages_queued);
		$display("Verdicts: %0d replies, %0d consumed, %0d errors, %0d dropped.",
			action_seen[ACT_REPLY], action_seen[ACT_CONSUMED], action_seen[ACT_ERROR],
			action_seen[ACT_DROP]);
		if (mismatches == 0) begin
			$display("No mismatches found");
		end else begin
			$display("Mismatches found");
		end
		$finish;
	end

endmodule
